// ===== rtl/md4_hash_engine_core_assert.svh =====
// Assertion helpers for the MD4 engine; clocked on clk, disabled in reset.
`ifndef MD4_HASH_ENGINE_CORE_ASSERT_SVH
`define MD4_HASH_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication.
`define MD4_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MD4_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/md4_pkg.sv =====
package md4_pkg;

    localparam int WORD_W       = 32;
    localparam int BUF_WORDS    = 16;
    localparam int BUF_AW       = $clog2(BUF_WORDS);
    localparam int ROUNDS       = 48;
    localparam int DIGEST_BYTES = 16;
    localparam int DLEN_W       = 5;
    localparam int COUNT_W      = 55;

    localparam logic [WORD_W-1:0] IV0 = 32'h67452301;
    localparam logic [WORD_W-1:0] IV1 = 32'hefcdab89;
    localparam logic [WORD_W-1:0] IV2 = 32'h98badcfe;
    localparam logic [WORD_W-1:0] IV3 = 32'h10325476;
    localparam logic [WORD_W-1:0] K_G = 32'h5a827999;
    localparam logic [WORD_W-1:0] K_H = 32'h6ed9eba1;
    localparam logic [7:0]        PAD_BYTE   = 8'h80;
    localparam logic [DLEN_W-1:0] DLEN_RESET = 5'd16;

    // Round groups
    localparam logic [1:0] GRP_F = 2'd0;
    localparam logic [1:0] GRP_G = 2'd1;
    localparam logic [1:0] GRP_H = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PAD  = 5'b00010,
        ST_COMP = 5'b00100,
        ST_FOLD = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    // Message word used by a round: F in order, G column order, H bit-reversed.
    function automatic logic [BUF_AW-1:0] msg_idx(input logic [5:0] rnd);
        logic [3:0] j;
        j = rnd[3:0];
        case (rnd[5:4])
            GRP_F:   msg_idx = j;
            GRP_G:   msg_idx = {j[1:0], j[3:2]};
            GRP_H:   msg_idx = {j[0], j[1], j[2], j[3]};
            default: msg_idx = '0;
        endcase
    endfunction

    // Left rotate amount per round.
    function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
        logic [4:0] s;
        s = 5'd3;
        case (rnd[5:4])
            GRP_F: begin
                case (rnd[1:0])
                    2'd0: s = 5'd3;
                    2'd1: s = 5'd7;
                    2'd2: s = 5'd11;
                    default: s = 5'd19;
                endcase
            end
            GRP_G: begin
                case (rnd[1:0])
                    2'd0: s = 5'd3;
                    2'd1: s = 5'd5;
                    2'd2: s = 5'd9;
                    default: s = 5'd13;
                endcase
            end
            default: begin
                case (rnd[1:0])
                    2'd0: s = 5'd3;
                    2'd1: s = 5'd9;
                    2'd2: s = 5'd11;
                    default: s = 5'd15;
                endcase
            end
        endcase
        rot_amt = s;
    endfunction

endpackage

// ===== rtl/md4_if.sv =====
// Message byte channel
interface md4_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;

    modport source (output valid, data_byte, byte_valid, last, input ready);
    modport sink   (input valid, data_byte, byte_valid, last, output ready);
endinterface

// Digest byte channel
interface md4_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] digest_byte;
    logic       digest_end;

    modport source (output valid, digest_byte, digest_end, input ready);
    modport sink   (input valid, digest_byte, digest_end, output ready);
endinterface

// ===== rtl/md4_ram.sv =====
module md4_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);
    logic [DATA_W-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/md4_round.sv =====
module md4_round (
    input  logic [5:0]  rnd,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    input  logic [31:0] m,
    output logic [31:0] a_new
);
    import md4_pkg::*;

    logic [31:0] fv;
    logic [31:0] kc;
    logic [31:0] sum;
    logic [63:0] dbl;

    // Boolean function and additive constant by round group
    always_comb
    begin
        case (rnd[5:4])
            GRP_F:
            begin
                fv = (b & c) | (~b & d);
                kc = '0;
            end
            GRP_G:
            begin
                fv = (b & c) | (b & d) | (c & d);
                kc = K_G;
            end
            default:
            begin
                fv = b ^ c ^ d;
                kc = K_H;
            end
        endcase
    end

    // Add and rotate left
    assign sum   = a + fv + m + kc;
    assign dbl   = {sum, sum} << rot_amt(rnd);
    assign a_new = dbl[63:32];
endmodule

// ===== rtl/md4_hash_engine_core.sv =====
// MD4 engine: one message item per cycle while a block fills.
// After the 64th byte of a block, input holds while the 48 rounds run (one round
// per cycle off the registered block RAM read) and through the chain fold.
// An item with last adds up to 18 padding writes and one or two compressions,
// then digest bytes leave via the output register, one per cycle unless stalled.
// Reset (rst_n, async low) loads the initial vector, clears counts, length = 16.
`include "md4_hash_engine_core_assert.svh"

module md4_hash_engine_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [md4_pkg::DLEN_W-1:0] cfg_wdata,
    md4_in_if.sink                    msg_in,
    md4_out_if.source                 dig_out
);
    import md4_pkg::*;

    state_t               state_reg, state_next;
    logic [5:0]           fill_reg, fill_next;
    logic [COUNT_W-1:0]   bcnt_reg, bcnt_next;
    logic [WORD_W-1:0]    word_reg, word_next;
    logic [WORD_W-1:0]    chain_reg [4];
    logic [WORD_W-1:0]    chain_next [4];
    logic [WORD_W-1:0]    a_reg, b_reg, c_reg, d_reg;
    logic [WORD_W-1:0]    a_next, b_next, c_next, d_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic [BUF_AW-1:0]    pidx_reg, pidx_next;
    logic                 first_reg, first_next;
    logic                 extra_reg, extra_next;
    logic                 fin_reg, fin_next;
    logic                 padded_reg, padded_next;
    logic [3:0]           ocnt_reg, ocnt_next;
    logic [DLEN_W-1:0]    dlen_reg;
    logic                 ovalid_reg, ovalid_next;
    logic [7:0]           obyte_reg, obyte_next;
    logic                 oend_reg, oend_next;

    logic                 accept;
    logic                 ram_we;
    logic [BUF_AW-1:0]    ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [WORD_W-1:0]    ram_rdata;
    logic [WORD_W-1:0]    pad_word;
    logic [63:0]          bit_len;
    logic [5:0]           rnd;
    logic [WORD_W-1:0]    round_out;
    logic [DLEN_W-1:0]    nbytes;
    logic                 oload;
    logic                 olast;
    logic [WORD_W-1:0]    osel;

    assign accept       = msg_in.valid && msg_in.ready;
    assign msg_in.ready = (state_reg == ST_IDLE);

    // Block buffer, one 32-bit word per entry
    md4_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (BUF_WORDS)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (msg_idx(cnt_reg)),
        .rdata (ram_rdata)
    );

    // Round datapath; round index is the read index of the cycle before
    assign rnd = cnt_reg - 6'd1;

    md4_round u_round (
        .rnd   (rnd),
        .a     (a_reg),
        .b     (b_reg),
        .c     (c_reg),
        .d     (d_reg),
        .m     (ram_rdata),
        .a_new (round_out)
    );

    // Padding word: kept bytes, 0x80, zeros
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (2'(i) < fill_reg[1:0])
                pad_word[8*i +: 8] = word_reg[8*i +: 8];
            else if (2'(i) == fill_reg[1:0])
                pad_word[8*i +: 8] = PAD_BYTE;
            else
                pad_word[8*i +: 8] = 8'h00;
        end
    end

    assign bit_len = {bcnt_reg, fill_reg, 3'b000};

    // Digest byte selection
    assign nbytes = (dlen_reg > DLEN_W'(DIGEST_BYTES)) ? DLEN_W'(DIGEST_BYTES) : dlen_reg;
    assign osel   = chain_reg[ocnt_reg[3:2]];
    assign oload  = (state_reg == ST_OUT) && (!ovalid_reg || dig_out.ready);
    assign olast  = ({1'b0, ocnt_reg} + DLEN_W'(1)) == nbytes;

    // Main sequencer
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        bcnt_next   = bcnt_reg;
        word_next   = word_reg;
        chain_next  = chain_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        cnt_next    = cnt_reg;
        pidx_next   = pidx_reg;
        first_next  = first_reg;
        extra_next  = extra_reg;
        fin_next    = fin_reg;
        padded_next = padded_reg;
        ocnt_next   = ocnt_reg;
        ovalid_next = ovalid_reg;
        obyte_next  = obyte_reg;
        oend_next   = oend_reg;
        ram_we      = 1'b0;
        ram_waddr   = pidx_reg;
        ram_wdata   = '0;

        if (dig_out.ready && !oload)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (msg_in.byte_valid)
                    begin
                        word_next[8*fill_reg[1:0] +: 8] = msg_in.data_byte;
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg[1:0] == 2'd3)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = fill_reg[5:2];
                            ram_wdata = word_next;
                        end
                    end
                    if (msg_in.byte_valid && fill_reg == 6'd63)
                    begin
                        // full block
                        bcnt_next   = bcnt_reg + COUNT_W'(1);
                        fin_next    = msg_in.last;
                        padded_next = 1'b0;
                        a_next      = chain_reg[0];
                        b_next      = chain_reg[1];
                        c_next      = chain_reg[2];
                        d_next      = chain_reg[3];
                        cnt_next    = '0;
                        state_next  = ST_COMP;
                    end
                    else if (msg_in.last)
                    begin
                        fin_next    = 1'b1;
                        padded_next = 1'b1;
                        pidx_next   = fill_next[5:2];
                        first_next  = 1'b1;
                        extra_next  = (fill_next >= 6'd56);
                        state_next  = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                ram_we    = 1'b1;
                ram_waddr = pidx_reg;
                if (first_reg)
                    ram_wdata = pad_word;
                else if (!extra_reg && pidx_reg == BUF_AW'(14))
                    ram_wdata = bit_len[31:0];
                else if (!extra_reg && pidx_reg == BUF_AW'(15))
                    ram_wdata = bit_len[63:32];
                else
                    ram_wdata = '0;
                first_next = 1'b0;
                pidx_next  = pidx_reg + BUF_AW'(1);
                if (pidx_reg == BUF_AW'(BUF_WORDS - 1))
                begin
                    a_next     = chain_reg[0];
                    b_next     = chain_reg[1];
                    c_next     = chain_reg[2];
                    d_next     = chain_reg[3];
                    cnt_next   = '0;
                    state_next = ST_COMP;
                end
            end

            ST_COMP:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg != 6'd0)
                begin
                    a_next = d_reg;
                    b_next = round_out;
                    c_next = b_reg;
                    d_next = c_reg;
                end
                if (cnt_reg == 6'(ROUNDS))
                begin
                    state_next = ST_FOLD;
                end
            end

            ST_FOLD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!padded_reg)
                begin
                    // last arrived with the block's final byte
                    padded_next = 1'b1;
                    pidx_next   = fill_reg[5:2];
                    first_next  = 1'b1;
                    extra_next  = 1'b0;
                    state_next  = ST_PAD;
                end
                else if (extra_reg)
                begin
                    extra_next = 1'b0;
                    pidx_next  = '0;
                    first_next = 1'b0;
                    state_next = ST_PAD;
                end
                else if (nbytes == '0)
                begin
                    chain_next = '{IV0, IV1, IV2, IV3};
                    fill_next  = '0;
                    bcnt_next  = '0;
                    fin_next   = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ocnt_next  = '0;
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (oload)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = osel[8*ocnt_reg[1:0] +: 8];
                    oend_next   = olast;
                    ocnt_next   = ocnt_reg + 4'd1;
                    if (olast)
                    begin
                        chain_next = '{IV0, IV1, IV2, IV3};
                        fill_next  = '0;
                        bcnt_next  = '0;
                        fin_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            bcnt_reg   <= '0;
            chain_reg  <= '{IV0, IV1, IV2, IV3};
            cnt_reg    <= '0;
            pidx_reg   <= '0;
            first_reg  <= 1'b0;
            extra_reg  <= 1'b0;
            fin_reg    <= 1'b0;
            padded_reg <= 1'b0;
            ocnt_reg   <= '0;
            ovalid_reg <= 1'b0;
            dlen_reg   <= DLEN_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            bcnt_reg   <= bcnt_next;
            chain_reg  <= chain_next;
            cnt_reg    <= cnt_next;
            pidx_reg   <= pidx_next;
            first_reg  <= first_next;
            extra_reg  <= extra_next;
            fin_reg    <= fin_next;
            padded_reg <= padded_next;
            ocnt_reg   <= ocnt_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                dlen_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        obyte_reg <= obyte_next;
        oend_reg  <= oend_next;
    end

    assign dig_out.valid       = ovalid_reg;
    assign dig_out.digest_byte = obyte_reg;
    assign dig_out.digest_end  = oend_reg;

    // Checks
    `MD4_ASSERT_NEXT(a_block_full, accept && msg_in.byte_valid && fill_reg == 6'd63,
        state_reg == ST_COMP && fill_reg == 6'd0, "full block did not start compression")
    `MD4_ASSERT_NOW(a_round_cnt, state_reg == ST_COMP, cnt_reg <= 6'(ROUNDS),
        "round counter overran")
    `MD4_ASSERT_NOW(a_out_src, $rose(ovalid_reg), $past(state_reg == ST_OUT),
        "digest item raised outside output phase")
    `MD4_ASSERT_NEXT(a_msg_clr, oload && olast,
        fill_reg == 6'd0 && bcnt_reg == '0 && chain_reg[0] == IV0 && state_reg == ST_IDLE,
        "message state not restored after digest")
endmodule

// ===== tb/sv/md4_hash_engine_core_test.sv =====
module md4_hash_engine_core_test;

    localparam int SINK_HOLD  = 400;   // long output back-pressure stretch
    localparam int SETTLE     = 200;   // padding plus two compressions, with margin
    localparam int QUIET_MAX  = 3000;  // cycles with no item moving on either side

    // Expected MD4 constants, kept independent of the design package
    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [31:0] ADD_G  = 32'h5a827999;
    localparam logic [31:0] ADD_H  = 32'h6ed9eba1;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    localparam int G_ORDER [16] = '{0, 4, 8, 12, 1, 5, 9, 13, 2, 6, 10, 14, 3, 7, 11, 15};
    localparam int H_ORDER [16] = '{0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15};
    localparam int ROT_F [4] = '{3, 7, 11, 19};
    localparam int ROT_G [4] = '{3, 5, 9, 13};
    localparam int ROT_H [4] = '{3, 9, 11, 15};

    typedef struct packed {
        logic [7:0] dbyte;
        logic       dend;
    } digest_byte_t;

    // Running MD4 predictor plus queue of digest bytes still owed by the block
    class md4_digest_scoreboard;
        logic [31:0]  chain [4];
        logic [7:0]   msg_buf [64];
        logic [5:0]   fill_cnt;
        logic [54:0]  block_cnt;
        logic [4:0]   digest_len;
        digest_byte_t digest_q [$];
        int           errors;
        int           messages;
        int           bytes_checked;

        function new();
            digest_len    = 5'd16;
            errors        = 0;
            messages      = 0;
            bytes_checked = 0;
            start_message();
        endfunction

        function void start_message();
            chain[0]  = INIT_A;
            chain[1]  = INIT_B;
            chain[2]  = INIT_C;
            chain[3]  = INIT_D;
            fill_cnt  = '0;
            block_cnt = '0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR: %s", msg);
        endfunction

        // 48 rounds over one block of sixteen words, folded into the chain
        function void compress(input logic [31:0] w [16]);
            logic [31:0] r [4];
            logic [31:0] x, y, z, f, m, sum;
            int t, s;
            for (int i = 0; i < 4; i++)
                r[i] = chain[i];
            for (int i = 0; i < 48; i++)
            begin
                t = (4 - i % 4) % 4;
                x = r[(t + 1) % 4];
                y = r[(t + 2) % 4];
                z = r[(t + 3) % 4];
                if (i < 16)
                begin
                    f = (x & y) | (~x & z);
                    m = w[i];
                    s = ROT_F[i % 4];
                end
                else if (i < 32)
                begin
                    f = (x & y) | (x & z) | (y & z);
                    m = w[G_ORDER[i - 16]] + ADD_G;
                    s = ROT_G[i % 4];
                end
                else
                begin
                    f = x ^ y ^ z;
                    m = w[H_ORDER[i - 32]] + ADD_H;
                    s = ROT_H[i % 4];
                end
                sum  = r[t] + f + m;
                r[t] = (sum << s) | (sum >> (32 - s));
            end
            for (int i = 0; i < 4; i++)
                chain[i] += r[i];
        endfunction

        // Little-endian words from the block buffer
        function void load_words(output logic [31:0] w [16]);
            for (int i = 0; i < 16; i++)
                w[i] = {msg_buf[4*i+3], msg_buf[4*i+2], msg_buf[4*i+1], msg_buf[4*i]};
        endfunction

        function void compress_block();
            logic [31:0] w [16];
            load_words(w);
            compress(w);
        endfunction

        // Padding, length and digest bytes for the current message
        function void finish_message();
            logic [31:0] w [16];
            logic [63:0] bit_len;
            int pos, n;
            pos = fill_cnt;
            msg_buf[pos] = PAD_MARK;
            pos++;
            // no room left for the length: spill into an extra block
            if (pos > 56)
            begin
                for (int k = pos; k < 64; k++)
                    msg_buf[k] = 8'h00;
                compress_block();
                pos = 0;
            end
            for (int k = pos; k < 56; k++)
                msg_buf[k] = 8'h00;
            load_words(w);
            bit_len = {block_cnt, fill_cnt, 3'b000};
            w[14]   = bit_len[31:0];
            w[15]   = bit_len[63:32];
            compress(w);
            n = (digest_len > 16) ? 16 : digest_len;
            for (int k = 0; k < n; k++)
                digest_q.push_back(digest_byte_t'{dbyte: chain[k/4][8*(k%4) +: 8],
                                                  dend: (k == n - 1)});
            messages++;
            start_message();
        endfunction

        // Called for every accepted input item
        function void note_item(logic [7:0] d, logic bv, logic lst);
            if (bv)
            begin
                msg_buf[fill_cnt] = d;
                fill_cnt++;
                if (fill_cnt == 0)
                begin
                    compress_block();
                    block_cnt++;
                end
            end
            if (lst)
                finish_message();
        endfunction

        // Called for every accepted digest byte
        function void check_digest(logic [7:0] b, logic e);
            digest_byte_t exp_item;
            if (digest_q.size() == 0)
            begin
                report($sformatf("unexpected digest byte %02h end %0b", b, e));
                return;
            end
            exp_item = digest_q.pop_front();
            bytes_checked++;
            if (b !== exp_item.dbyte)
                report($sformatf("digest_byte exp %02h got %02h", exp_item.dbyte, b));
            if (e !== exp_item.dend)
                report($sformatf("digest_end exp %0b got %0b", exp_item.dend, e));
        endfunction

        function int pending();
            return digest_q.size();
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [md4_pkg::DLEN_W-1:0] cfg_wdata;

    md4_in_if  msg_in();
    md4_out_if dig_out();

    md4_digest_scoreboard sb;
    int  idle_pct;
    int  items_sent;
    int  hold_left;
    bit  sink_hold_req;

    md4_hash_engine_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .msg_in    (msg_in),
        .dig_out   (dig_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one item, with a random gap first, and wait for its handshake
    task automatic send_item(input logic [7:0] d, input logic bv, input logic lst);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            msg_in.valid <= 1'b0;
            @(posedge clk);
        end
        msg_in.valid      <= 1'b1;
        msg_in.data_byte  <= d;
        msg_in.byte_valid <= bv;
        msg_in.last       <= lst;
        @(posedge clk);
        while (!msg_in.ready)
            @(posedge clk);
        sb.note_item(d, bv, lst);
        if (bv || lst)
            items_sent++;
    endtask

    // One message of random bytes; the end marker rides on the final byte or
    // comes as an item of its own; a few ignored bytes are mixed in
    task automatic send_message(input int nbytes);
        bit sep_last;
        sep_last = (nbytes == 0) || ($urandom_range(3) == 0);
        for (int k = 0; k < nbytes; k++)
        begin
            if ($urandom_range(9) == 0)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, !sep_last && k == nbytes - 1);
        end
        if (sep_last)
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    // Stop offering and wait for every owed digest byte
    task automatic drain();
        msg_in.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_length(input logic [4:0] len);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_wdata <= len;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.digest_len = len;
    endtask

    // Optional message at a padding boundary, then short random messages
    task automatic random_phase(input int budget, input int edge_len);
        int start_cnt;
        start_cnt = items_sent;
        if (edge_len > 0)
            send_message(edge_len);
        while (items_sent - start_cnt < budget)
        begin
            send_message($urandom_range(9));
            if ($urandom_range(9) == 0)
                drain();
        end
    endtask

    // Digest sink: check accepted bytes, then pick ready for the next cycle
    initial
    begin
        dig_out.ready <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && dig_out.valid && dig_out.ready)
                sb.check_digest(dig_out.digest_byte, dig_out.digest_end);
            if (sink_hold_req)
            begin
                hold_left     = SINK_HOLD;
                sink_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                dig_out.ready <= 1'b0;
            end
            else
                dig_out.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Watchdog on cycles in which no item moves
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX)
        begin
            @(posedge clk);
            if ((msg_in.valid && msg_in.ready) || (dig_out.valid && dig_out.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("ERROR: no progress for %0d cycles, %0d digest bytes still owed",
                 QUIET_MAX, sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        sb            = new();
        idle_pct      = 19;
        items_sent    = 0;
        sink_hold_req = 1'b0;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        msg_in.valid       <= 1'b0;
        msg_in.data_byte   <= 8'h00;
        msg_in.byte_valid  <= 1'b0;
        msg_in.last        <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, single extreme bytes, ignored bytes, "abc"
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'ha5, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);

        // Reset length; 55 bytes just fit padding and length in one block
        random_phase(20, 55);

        // Shortest digest; 56 bytes force the extra padding block
        write_length(5'd1);
        send_item(8'h00, 1'b0, 1'b1);
        random_phase(15, 56);

        // No digest bytes at all, then an out-of-range length that saturates
        write_length(5'd0);
        random_phase(6, 0);
        write_length(5'd31);
        random_phase(8, 0);

        // Full length with the sink held off: one whole block, then backlog
        write_length(5'd16);
        sink_hold_req = 1'b1;
        random_phase(15, 64);

        // Mid length with no idling on either side
        write_length(5'd7);
        idle_pct = 0;
        random_phase(20, 0);
        idle_pct = 19;

        drain();
        repeat (SETTLE) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d digest bytes never arrived", sb.pending()));

        $display("Sent %0d message items in %0d messages, checked %0d digest bytes",
                 items_sent, sb.messages, sb.bytes_checked);
        $display("Digest lengths 16, 1, 0, 31, 7; padding edges at 55, 56 and 64 bytes");
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/md4_pkg.sv
rtl/md4_if.sv
rtl/md4_ram.sv
rtl/md4_round.sv
rtl/md4_hash_engine_core.sv
tb/sv/md4_hash_engine_core_test.sv
